// ----- rtl/mass_pkg.sv -----
`default_nettype none

package mass_pkg;

  localparam int NUM_AXES      = 4;
  localparam int AXIS_WIDTH    = 2;
  localparam int COUNT_WIDTH   = 24;
  localparam int RATE_WIDTH    = 16;
  localparam int SPMM_WIDTH    = 16;
  localparam int PROD_WIDTH    = RATE_WIDTH + SPMM_WIDTH;
  localparam int WAIT_WIDTH    = 26;
  localparam int BIT_IDX_WIDTH = $clog2(WAIT_WIDTH);
  localparam int CFG_IDX_WIDTH = 2;
  localparam int FLAGS_COMBOS  = 16;

  localparam logic [WAIT_WIDTH-1:0] MIN_WAIT         = WAIT_WIDTH'(100);
  localparam logic [WAIT_WIDTH-1:0] TICKS_PER_MINUTE = WAIT_WIDTH'(60000000);

  localparam logic [AXIS_WIDTH-1:0] AX_X = 2'd0;
  localparam logic [AXIS_WIDTH-1:0] AX_Y = 2'd1;
  localparam logic [AXIS_WIDTH-1:0] AX_Z = 2'd2;
  localparam logic [AXIS_WIDTH-1:0] AX_E = 2'd3;

  localparam logic REQ_MOVE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [AXIS_WIDTH-1:0] NEXT_AXIS [NUM_AXES][FLAGS_COMBOS] = '{
    '{AX_E, AX_X, AX_Y, AX_Y, AX_Z, AX_X, AX_Y, AX_Y,
      AX_E, AX_E, AX_E, AX_Y, AX_E, AX_E, AX_Y, AX_Y},
    '{AX_E, AX_X, AX_Y, AX_X, AX_Z, AX_X, AX_Y, AX_X,
      AX_E, AX_E, AX_E, AX_E, AX_E, AX_E, AX_E, AX_E},
    '{AX_E, AX_X, AX_Y, AX_X, AX_Z, AX_X, AX_Y, AX_X,
      AX_E, AX_X, AX_Y, AX_X, AX_E, AX_X, AX_Y, AX_X},
    '{AX_E, AX_X, AX_Y, AX_X, AX_Z, AX_X, AX_Y, AX_X,
      AX_E, AX_X, AX_Y, AX_X, AX_Z, AX_X, AX_Y, AX_X}
  };

  typedef struct packed {
    logic                     step_now;
    logic                     latch_move;
    logic                     mul;
    logic                     div_step;
    logic                     store_wait;
    logic                     apply;
    logic [AXIS_WIDTH-1:0]    axis;
    logic [BIT_IDX_WIDTH-1:0] div_bit;
  } cmd_t;

  typedef struct packed {
    logic running;
    logic out_valid;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/mass_ctrl.sv -----
`default_nettype none

module mass_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire              req_type,
  input  wire              out_stall,
  input  mass_pkg::status_t status,
  output mass_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;

  localparam logic [mass_pkg::BIT_IDX_WIDTH-1:0] TOP_BIT =
    mass_pkg::BIT_IDX_WIDTH'(mass_pkg::WAIT_WIDTH - 1);

  logic [2:0]                          state;
  logic [2:0]                          state_next;
  logic [mass_pkg::AXIS_WIDTH-1:0]     axis;
  logic [mass_pkg::AXIS_WIDTH-1:0]     axis_next;
  logic [mass_pkg::BIT_IDX_WIDTH-1:0]  bit_cnt;
  logic [mass_pkg::BIT_IDX_WIDTH-1:0]  bit_cnt_next;
  logic                                accept;

  assign in_stall = (state != S_IDLE) || (status.out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next     = state;
    axis_next      = axis;
    bit_cnt_next   = bit_cnt;
    cmd            = '0;
    cmd.axis       = axis;
    cmd.div_bit    = bit_cnt;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_type == mass_pkg::REQ_MOVE && !status.running) begin
            cmd.latch_move = 1'b1;
            axis_next      = mass_pkg::AX_X;
            state_next     = S_MUL;
          end else begin
            cmd.step_now = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.mul      = 1'b1;
        bit_cnt_next = TOP_BIT;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (bit_cnt == '0) begin
          state_next = S_STORE;
        end else begin
          bit_cnt_next = bit_cnt - 1'b1;
        end
      end
      S_STORE: begin
        cmd.store_wait = 1'b1;
        if (axis == mass_pkg::AX_E) begin
          state_next = S_APPLY;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = S_MUL;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      axis    <= mass_pkg::AX_X;
      bit_cnt <= '0;
    end else begin
      state   <= state_next;
      axis    <= axis_next;
      bit_cnt <= bit_cnt_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mass_datapath.sv -----
`default_nettype none

module mass_datapath #(
  parameter int COUNT_WIDTH = mass_pkg::COUNT_WIDTH
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  mass_pkg::cmd_t                      cmd,
  output mass_pkg::status_t                   status,
  input  wire                                 cfg_we,
  input  wire [mass_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  wire [mass_pkg::SPMM_WIDTH-1:0]      cfg_data,
  input  wire                                 req_type,
  input  wire signed [COUNT_WIDTH-1:0]        move_x,
  input  wire signed [COUNT_WIDTH-1:0]        move_y,
  input  wire signed [COUNT_WIDTH-1:0]        move_z,
  input  wire signed [COUNT_WIDTH-1:0]        move_e,
  input  wire [mass_pkg::RATE_WIDTH-1:0]      feed_rate,
  input  wire [mass_pkg::RATE_WIDTH-1:0]      extrude_rate,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [mass_pkg::NUM_AXES-1:0]       step_toggle,
  output logic [mass_pkg::NUM_AXES-1:0]       direction,
  output logic                                busy_res,
  output logic                                move_done,
  output logic                                move_rejected
);

  localparam int NA = mass_pkg::NUM_AXES;
  localparam int AW = mass_pkg::AXIS_WIDTH;
  localparam int WW = mass_pkg::WAIT_WIDTH;
  localparam int PW = mass_pkg::PROD_WIDTH;

  logic [mass_pkg::SPMM_WIDTH-1:0] spmm [NA];
  logic [mass_pkg::RATE_WIDTH-1:0] feed_q;
  logic [mass_pkg::RATE_WIDTH-1:0] ext_q;
  logic [COUNT_WIDTH-1:0]          remaining [NA];
  logic [WW-1:0]                   axis_wait [NA];
  logic [WW-1:0]                   wait_count;
  logic [NA-1:0]                   active;
  logic [NA-1:0]                   active_next;
  logic [NA-1:0]                   dir_bits;
  logic [AW-1:0]                   cur_axis;
  logic                            running;
  logic                            running_next;

  logic [PW-1:0]                   prod;
  logic [PW-1:0]                   rem;
  logic [WW-1:0]                   quo;
  logic [PW:0]                     rem_shift;
  logic                            rem_ge;
  logic [WW-1:0]                   wait_val;
  logic [mass_pkg::RATE_WIDTH-1:0] rate_sel;

  logic signed [COUNT_WIDTH-1:0]   move_in [NA];
  logic [AW-1:0]                   next_ax;
  logic [AW-1:0]                   tgl_axis;
  logic                            tick_run;
  logic                            do_tgl;
  logic                            do_dec;
  logic                            finish;
  logic                            reject;
  logic                            rem_low;
  logic                            load_out;

  assign move_in[0] = move_x;
  assign move_in[1] = move_y;
  assign move_in[2] = move_z;
  assign move_in[3] = move_e;

  assign status.running   = running;
  assign status.out_valid = out_valid;

  assign rate_sel  = (cmd.axis == mass_pkg::AX_E) ? ext_q : feed_q;
  assign rem_shift = {rem, mass_pkg::TICKS_PER_MINUTE[cmd.div_bit]};
  assign rem_ge    = rem_shift >= {1'b0, prod};
  assign wait_val  = (prod == '0 || quo < mass_pkg::MIN_WAIT) ? mass_pkg::MIN_WAIT : quo;

  always_comb begin
    next_ax      = mass_pkg::NEXT_AXIS[cur_axis][active];
    tick_run     = cmd.step_now && (req_type == mass_pkg::REQ_TICK) && running;
    reject       = cmd.step_now && (req_type == mass_pkg::REQ_MOVE);
    do_dec       = tick_run && (wait_count != '0);
    finish       = tick_run && (wait_count == '0) && (active == '0);
    do_tgl       = cmd.apply || (tick_run && (wait_count == '0) && (active != '0));
    tgl_axis     = cmd.apply ? mass_pkg::AX_X : next_ax;
    rem_low      = remaining[tgl_axis] <= COUNT_WIDTH'(1);
    load_out     = cmd.step_now || cmd.apply;
    active_next  = cmd.apply ? '1 : active;
    if (do_tgl && rem_low) begin
      active_next[tgl_axis] = 1'b0;
    end
    running_next = running;
    if (cmd.apply) begin
      running_next = 1'b1;
    end else if (finish) begin
      running_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NA; i++) begin
        spmm[i] <= mass_pkg::SPMM_WIDTH'(1);
      end
    end else if (cfg_we) begin
      spmm[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_move) begin
      feed_q <= feed_rate;
      ext_q  <= extrude_rate;
      for (int i = 0; i < NA; i++) begin
        remaining[i] <= move_in[i][COUNT_WIDTH-1] ? COUNT_WIDTH'(-move_in[i])
                                                   : COUNT_WIDTH'(move_in[i]);
      end
    end else if (do_tgl) begin
      remaining[tgl_axis] <= rem_low ? '0 : remaining[tgl_axis] - 1'b1;
    end
    if (cmd.mul) begin
      prod <= PW'(rate_sel) * PW'(spmm[cmd.axis]);
      rem  <= '0;
      quo  <= '0;
    end else if (cmd.div_step) begin
      rem  <= rem_ge ? PW'(rem_shift - {1'b0, prod}) : PW'(rem_shift);
      quo  <= {quo[WW-2:0], rem_ge};
    end
    if (cmd.store_wait) begin
      axis_wait[cmd.axis] <= wait_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= '0;
      running    <= 1'b0;
      cur_axis   <= mass_pkg::AX_X;
      wait_count <= '0;
      dir_bits   <= '0;
    end else begin
      active  <= active_next;
      running <= running_next;
      if (cmd.latch_move) begin
        for (int i = 0; i < NA; i++) begin
          dir_bits[i] <= move_in[i][COUNT_WIDTH-1];
        end
      end
      if (do_tgl) begin
        cur_axis   <= tgl_axis;
        wait_count <= axis_wait[tgl_axis];
      end else if (do_dec) begin
        wait_count <= wait_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      step_toggle   <= do_tgl ? NA'(1) << tgl_axis : '0;
      direction     <= dir_bits;
      busy_res      <= running_next;
      move_done     <= finish;
      move_rejected <= reject;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/multi_axis_step_sequencer.sv -----
`default_nettype none

// Channel   Handshake            Payload
// cfg       cfg_we               cfg_index, cfg_data
// in        in_valid / in_stall  req_type, move_x..move_e, feed_rate, extrude_rate
// out       out_valid / out_stall step_toggle, direction, busy_res, move_done, move_rejected
//
// A tick, or a move that arrives while busy, is answered straight from idle; the result is registered.
// An accepted move is computed axis by axis, X to E: per axis a multiply,
// one restoring divider step per quotient bit, and one store; the X toggle follows.
// in_stall is high while a move is being computed and while a held result is stalled.
// Reset is synchronous; registers come up as 1 steps/mm, idle, no result pending.

module multi_axis_step_sequencer #(
  parameter int COUNT_WIDTH = mass_pkg::COUNT_WIDTH
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire [mass_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  wire [mass_pkg::SPMM_WIDTH-1:0]      cfg_data,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 req_type,
  input  wire signed [COUNT_WIDTH-1:0]        move_x,
  input  wire signed [COUNT_WIDTH-1:0]        move_y,
  input  wire signed [COUNT_WIDTH-1:0]        move_z,
  input  wire signed [COUNT_WIDTH-1:0]        move_e,
  input  wire [mass_pkg::RATE_WIDTH-1:0]      feed_rate,
  input  wire [mass_pkg::RATE_WIDTH-1:0]      extrude_rate,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [mass_pkg::NUM_AXES-1:0]       step_toggle,
  output logic [mass_pkg::NUM_AXES-1:0]       direction,
  output logic                                busy_res,
  output logic                                move_done,
  output logic                                move_rejected
);

  mass_pkg::cmd_t    cmd;
  mass_pkg::status_t status;

  mass_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mass_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .move_x        (move_x),
    .move_y        (move_y),
    .move_z        (move_z),
    .move_e        (move_e),
    .feed_rate     (feed_rate),
    .extrude_rate  (extrude_rate),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .step_toggle   (step_toggle),
    .direction     (direction),
    .busy_res      (busy_res),
    .move_done     (move_done),
    .move_rejected (move_rejected)
  );

endmodule

`default_nettype wire

// ----- tb/multi_axis_step_sequencer_tb.sv -----
module multi_axis_step_sequencer_tb;
  import mass_pkg::*;

  localparam int unsigned USEC_PER_MIN = 60000000;
  localparam int unsigned MIN_DELAY    = 100;

  localparam logic [AXIS_WIDTH-1:0] AXIS_AFTER [NUM_AXES][FLAGS_COMBOS] = '{
    '{AX_E, AX_X, AX_Y, AX_Y, AX_Z, AX_X, AX_Y, AX_Y,
      AX_E, AX_E, AX_E, AX_Y, AX_E, AX_E, AX_Y, AX_Y},
    '{AX_E, AX_X, AX_Y, AX_X, AX_Z, AX_X, AX_Y, AX_X,
      AX_E, AX_E, AX_E, AX_E, AX_E, AX_E, AX_E, AX_E},
    '{AX_E, AX_X, AX_Y, AX_X, AX_Z, AX_X, AX_Y, AX_X,
      AX_E, AX_X, AX_Y, AX_X, AX_E, AX_X, AX_Y, AX_X},
    '{AX_E, AX_X, AX_Y, AX_X, AX_Z, AX_X, AX_Y, AX_X,
      AX_E, AX_X, AX_Y, AX_X, AX_Z, AX_X, AX_Y, AX_X}
  };

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    SPMM_X_REG, SPMM_Y_REG, SPMM_Z_REG, SPMM_E_REG
  } spmm_reg_e;

  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_e;

  typedef struct packed {
    logic                                   req;
    logic [NUM_AXES-1:0][COUNT_WIDTH-1:0]   steps;
    logic [RATE_WIDTH-1:0]                  feed;
    logic [RATE_WIDTH-1:0]                  ext;
  } seq_item_t;

  typedef struct packed {
    logic [NUM_AXES-1:0] toggle;
    logic [NUM_AXES-1:0] dir;
    logic                busy;
    logic                done;
    logic                rejected;
  } seq_result_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_IDX_WIDTH-1:0]   cfg_index;
  logic [SPMM_WIDTH-1:0]      cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       req_type;
  logic [COUNT_WIDTH-1:0]     move_x;
  logic [COUNT_WIDTH-1:0]     move_y;
  logic [COUNT_WIDTH-1:0]     move_z;
  logic [COUNT_WIDTH-1:0]     move_e;
  logic [RATE_WIDTH-1:0]      feed_rate;
  logic [RATE_WIDTH-1:0]      extrude_rate;
  logic                       out_valid;
  logic                       out_stall;
  logic [NUM_AXES-1:0]        step_toggle;
  logic [NUM_AXES-1:0]        direction;
  logic                       busy_res;
  logic                       move_done;
  logic                       move_rejected;

  logic [SPMM_WIDTH-1:0]      spmm_model [NUM_AXES];
  logic [AXIS_WIDTH-1:0]      axis_now;
  logic [COUNT_WIDTH-1:0]     steps_left [NUM_AXES];
  logic [NUM_AXES-1:0]        axes_active;
  logic [WAIT_WIDTH-1:0]      axis_delay [NUM_AXES];
  logic [WAIT_WIDTH-1:0]      delay_left;
  logic [NUM_AXES-1:0]        dir_latched;
  bit                         seq_running;

  seq_result_t                step_results_due [$];
  idle_mode_e                 feed_idle;
  idle_mode_e                 sink_idle;
  int                         long_hold;
  int                         items_sent;
  int                         moves_completed;
  int                         mismatches;

  multi_axis_step_sequencer i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .move_x        (move_x),
    .move_y        (move_y),
    .move_z        (move_z),
    .move_e        (move_e),
    .feed_rate     (feed_rate),
    .extrude_rate  (extrude_rate),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .step_toggle   (step_toggle),
    .direction     (direction),
    .busy_res      (busy_res),
    .move_done     (move_done),
    .move_rejected (move_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [WAIT_WIDTH-1:0] pulse_delay(input logic [RATE_WIDTH-1:0] rate,
                                                        input logic [SPMM_WIDTH-1:0] sp);
    logic [PROD_WIDTH-1:0] prod;
    logic [PROD_WIDTH-1:0] quo;
    prod = rate * sp;
    if (prod == 0) return WAIT_WIDTH'(MIN_DELAY);
    quo = USEC_PER_MIN / prod;
    if (quo < MIN_DELAY) return WAIT_WIDTH'(MIN_DELAY);
    return quo[WAIT_WIDTH-1:0];
  endfunction

  function automatic logic [NUM_AXES-1:0] pulse_axis(input logic [AXIS_WIDTH-1:0] a);
    if (steps_left[a] <= 1) begin
      steps_left[a] = '0;
      axes_active[a] = 1'b0;
    end else begin
      steps_left[a] = steps_left[a] - 1'b1;
    end
    delay_left = axis_delay[a];
    return NUM_AXES'(1) << a;
  endfunction

  function automatic seq_result_t step_sequencer(input seq_item_t it);
    seq_result_t r;
    logic [COUNT_WIDTH-1:0] mag;
    int a;
    r = '0;
    if (it.req == REQ_MOVE) begin
      if (seq_running) begin
        r.rejected = 1'b1;
      end else begin
        for (a = 0; a < NUM_AXES; a++) begin
          mag = it.steps[a];
          dir_latched[a] = mag[COUNT_WIDTH-1];
          if (mag[COUNT_WIDTH-1]) mag = ~mag + 1'b1;
          steps_left[a] = mag;
          axis_delay[a] = pulse_delay((a == AX_E) ? it.ext : it.feed, spmm_model[a]);
        end
        axes_active = '1;
        axis_now = AX_X;
        seq_running = 1'b1;
        r.toggle = pulse_axis(AX_X);
      end
    end else if (seq_running) begin
      if (delay_left != 0) begin
        delay_left = delay_left - 1'b1;
      end else if (axes_active == 0) begin
        seq_running = 1'b0;
        r.done = 1'b1;
        moves_completed++;
      end else begin
        axis_now = AXIS_AFTER[axis_now][axes_active];
        r.toggle = pulse_axis(axis_now);
      end
    end
    r.dir = dir_latched;
    r.busy = seq_running;
    return r;
  endfunction

  function automatic int draw_gap(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19) : 0;
      default:    return $urandom_range(0, 19);
    endcase
  endfunction

  function automatic seq_item_t random_item(input logic req);
    seq_item_t it;
    int a;
    it.req = req;
    for (a = 0; a < NUM_AXES; a++) it.steps[a] = COUNT_WIDTH'($urandom);
    it.feed = RATE_WIDTH'($urandom);
    it.ext = RATE_WIDTH'($urandom);
    return it;
  endfunction

  function automatic seq_item_t build_move(input int x, input int y, input int z, input int e,
                                           input int feed, input int ext);
    seq_item_t it;
    it.req = REQ_MOVE;
    it.steps[AX_X] = COUNT_WIDTH'(x);
    it.steps[AX_Y] = COUNT_WIDTH'(y);
    it.steps[AX_Z] = COUNT_WIDTH'(z);
    it.steps[AX_E] = COUNT_WIDTH'(e);
    it.feed = RATE_WIDTH'(feed);
    it.ext = RATE_WIDTH'(ext);
    return it;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] random_count();
    int mag;
    mag = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
    return COUNT_WIDTH'($urandom_range(0, 1) ? -mag : mag);
  endfunction

  // slowest rate that keeps the per-step wait near 500 ticks
  function automatic logic [RATE_WIDTH-1:0] lowest_rate(input logic [SPMM_WIDTH-1:0] sp);
    int unsigned lo;
    lo = USEC_PER_MIN / (500 * sp) + 1;
    if (lo > 65535) lo = 65535;
    return RATE_WIDTH'(lo);
  endfunction

  function automatic logic [RATE_WIDTH-1:0] random_rate(input logic [RATE_WIDTH-1:0] lo);
    int unsigned hi;
    hi = (lo * 4 > 65535) ? 65535 : lo * 4;
    case ($urandom_range(0, 7))
      0:       return '0;
      1, 2, 3: return RATE_WIDTH'($urandom_range(lo, hi));
      default: return RATE_WIDTH'($urandom_range(lo, 65535));
    endcase
  endfunction

  function automatic seq_item_t random_move(input logic [RATE_WIDTH-1:0] lo_feed,
                                            input logic [RATE_WIDTH-1:0] lo_ext);
    seq_item_t it;
    int a;
    it.req = REQ_MOVE;
    for (a = 0; a < NUM_AXES; a++) it.steps[a] = random_count();
    it.feed = random_rate(lo_feed);
    it.ext = random_rate(lo_ext);
    return it;
  endfunction

  function automatic void compare_field(input string name, input logic [NUM_AXES-1:0] exp_v,
                                        input logic [NUM_AXES-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic send_item(input seq_item_t it);
    int gap;
    gap = draw_gap(feed_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= it.req;
    move_x       <= it.steps[AX_X];
    move_y       <= it.steps[AX_Y];
    move_z       <= it.steps[AX_Z];
    move_e       <= it.steps[AX_E];
    feed_rate    <= it.feed;
    extrude_rate <= it.ext;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_results_due.push_back(step_sequencer(it));
    items_sent++;
  endtask

  task automatic settle_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (step_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input spmm_reg_e idx, input logic [SPMM_WIDTH-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    spmm_model[idx] = value;
  endtask

  task automatic load_steps_per_mm(input logic [SPMM_WIDTH-1:0] sx, input logic [SPMM_WIDTH-1:0] sy,
                                   input logic [SPMM_WIDTH-1:0] sz, input logic [SPMM_WIDTH-1:0] se);
    settle_results();
    write_reg(SPMM_X_REG, sx);
    write_reg(SPMM_Y_REG, sy);
    write_reg(SPMM_Z_REG, sz);
    write_reg(SPMM_E_REG, se);
    cfg_we <= 1'b0;
  endtask

  // tick until the move finishes, with an occasional rejected move mixed in when with_noise is set
  task automatic run_to_completion(input bit with_noise);
    while (seq_running) begin
      if (with_noise && $urandom_range(0, 47) == 0) send_item(random_item(REQ_MOVE));
      else send_item(random_item(REQ_TICK));
    end
  endtask

  task automatic test_idle_ticks();
    repeat (3) send_item(random_item(REQ_TICK));
  endtask

  task automatic test_reset_rates();
    send_item(build_move(0, 0, 0, 0, 65535, 65535));
    run_to_completion(1'b0);
    send_item(build_move(0, 0, 0, 0, 0, 0));
    run_to_completion(1'b0);
  endtask

  task automatic test_clamp_edges();
    load_steps_per_mm(10, 10, 10, 10);
    send_item(build_move(3, -2, 1, -1, 60000, 59000));
    run_to_completion(1'b0);
    send_item(build_move(0, 5, 0, 2, 60001, 59999));
    run_to_completion(1'b0);
  endtask

  task automatic test_register_extremes();
    load_steps_per_mm(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(build_move(-1, -1, -1, -1, 1, 0));
    send_item(build_move(-8388608, 8388607, -8388608, 8388607, 65535, 65535));
    send_item(build_move(8388607, -8388608, 0, -1, 0, 0));
    run_to_completion(1'b0);
    load_steps_per_mm(1, 16'hFFFF, 1, 16'hFFFF);
    send_item(build_move(1, 2, 0, 3, 65535, 65535));
    run_to_completion(1'b0);
  endtask

  task automatic test_axis_orders();
    load_steps_per_mm(2000, 3000, 4000, 5000);
    send_item(build_move(6, 0, 0, 0, 0, 0));
    run_to_completion(1'b0);
    send_item(build_move(0, -7, 0, 0, 0, 0));
    run_to_completion(1'b0);
    send_item(build_move(0, 0, 6, 0, 0, 0));
    run_to_completion(1'b0);
    send_item(build_move(0, 0, 0, -6, 0, 0));
    run_to_completion(1'b0);
    send_item(build_move(2, 4, -3, 5, 0, 0));
    run_to_completion(1'b0);
  endtask

  task automatic test_backpressure();
    feed_idle = IDLE_NONE;
    sink_idle = IDLE_NONE;
    load_steps_per_mm(100, 200, 300, 400);
    send_item(build_move(2, -3, 1, 0, 1500, 700));
    long_hold = 250;
    repeat (60) send_item(random_item(REQ_TICK));
    settle_results();
    run_to_completion(1'b1);
  endtask

  task automatic test_random_moves();
    int start_moves;
    int start_items;
    int phase;
    int a;
    logic [SPMM_WIDTH-1:0] sp [NUM_AXES];
    logic [SPMM_WIDTH-1:0] min_xyz;
    start_moves = moves_completed;
    start_items = items_sent;
    phase = 0;
    while (moves_completed - start_moves < 30 || items_sent - start_items < 750) begin
      for (a = 0; a < NUM_AXES; a++) begin
        sp[a] = ($urandom_range(0, 7) == 0) ? 16'hFFFF : SPMM_WIDTH'($urandom_range(2, 65535));
      end
      load_steps_per_mm(sp[AX_X], sp[AX_Y], sp[AX_Z], sp[AX_E]);
      min_xyz = sp[AX_X];
      if (sp[AX_Y] < min_xyz) min_xyz = sp[AX_Y];
      if (sp[AX_Z] < min_xyz) min_xyz = sp[AX_Z];
      if (phase == 0) begin
        feed_idle = IDLE_NONE;
        sink_idle = IDLE_NONE;
      end else begin
        feed_idle = idle_mode_e'($urandom_range(0, 2));
        sink_idle = idle_mode_e'($urandom_range(0, 2));
      end
      repeat (5) begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) send_item(random_item(REQ_TICK));
        end
        send_item(random_move(lowest_rate(min_xyz), lowest_rate(sp[AX_E])));
        run_to_completion(1'b1);
      end
      phase++;
    end
  endtask

  initial begin : result_sink
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold > 0) begin
        hold = long_hold;
        long_hold = 0;
      end else begin
        hold = draw_gap(sink_idle);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    seq_result_t due;
    if (!rst && out_valid && !out_stall) begin
      if (step_results_due.size() == 0) begin
        $error("result with no pending transaction");
        mismatches++;
      end else begin
        due = step_results_due.pop_front();
        compare_field("step_toggle", due.toggle, step_toggle);
        compare_field("direction", due.dir, direction);
        compare_field("busy_res", due.busy, busy_res);
        compare_field("move_done", due.done, move_done);
        compare_field("move_rejected", due.rejected, move_rejected);
      end
    end
  end

  initial begin
    #50_000_000;
    $display("multi_axis_step_sequencer test failed");
    $finish;
  end

  initial begin
    int a;
    for (a = 0; a < NUM_AXES; a++) begin
      spmm_model[a] = 1;
      steps_left[a] = '0;
      axis_delay[a] = WAIT_WIDTH'(MIN_DELAY);
    end
    axis_now        = AX_X;
    axes_active     = '0;
    delay_left      = '0;
    dir_latched     = '0;
    seq_running     = 1'b0;
    feed_idle       = IDLE_LIGHT;
    sink_idle       = IDLE_LIGHT;
    long_hold       = 0;
    items_sent      = 0;
    moves_completed = 0;
    mismatches      = 0;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= SPMM_X_REG;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    req_type     <= REQ_TICK;
    move_x       <= '0;
    move_y       <= '0;
    move_z       <= '0;
    move_e       <= '0;
    feed_rate    <= '0;
    extrude_rate <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_ticks();
    test_reset_rates();
    test_clamp_edges();
    test_register_extremes();
    test_axis_orders();
    test_backpressure();
    test_random_moves();
    settle_results();
    repeat (150) @(posedge clk);
    if (mismatches == 0 && step_results_due.size() == 0) begin
      $display("multi_axis_step_sequencer test passed");
    end else begin
      $display("multi_axis_step_sequencer test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mass_pkg.sv
rtl/mass_ctrl.sv
rtl/mass_datapath.sv
rtl/multi_axis_step_sequencer.sv
tb/multi_axis_step_sequencer_tb.sv
